>>> hw/rtl/lf2d_pkg.sv
// Package: shared constants and types for the legacy float to double converter.
`timescale 1ns / 1ps
package lf2d_pkg;
  localparam int unsigned RawW   = 48;
  localparam int unsigned DblW   = 64;
  localparam int unsigned FracW  = 27;
  localparam int unsigned PosW   = 5;
  localparam int unsigned BexpW  = 11;
  localparam int unsigned AddrW  = 3;

  typedef enum logic {
    FMT_B2_36  = 1'b0,
    FMT_B16_32 = 1'b1
  } src_fmt_e;

  localparam logic [AddrW-1:0] RegSrcFmt = 3'd0;

  // Unpacked source operand: sign, fraction (no hidden bit) and unbiased scale
  typedef struct packed {
    logic              sign;
    logic [FracW-1:0]  frac;
    logic signed [10:0] scale;
  } operand_t;
endpackage

>>> hw/rtl/legacy_float_to_ieee_double_top.sv
// Converter with one item per cycle while the skid stage is empty: an input register,
// combinational unpack and leading-one normalise logic and an output register; a new result
// waits in a skid stage while the output stalls. A word passes the input register and then the
// output register. source_format (0: 36-bit base-2, 1: 32-bit base-16) is at APB address 0 and
// should be written only while no word is in flight.
`timescale 1ns / 1ps
module legacy_float_to_ieee_double_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [lf2d_pkg::RawW-1:0]   s_axis_tdata,  // [47:0] raw_word
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [lf2d_pkg::DblW-1:0]   m_axis_tdata,  // [63:0] ieee_double
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lf2d_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lf2d_pkg::*;

  src_fmt_e            fmt_q;
  logic                in_vld_q, out_vld_q, skid_vld_q;
  logic [RawW-1:0]     raw_q;
  logic [DblW-1:0]     out_q, skid_q, dbl;
  operand_t            op;

  assign pready = 1'b1;
  assign prdata = (paddr == RegSrcFmt) ? {31'd0, fmt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_B2_36;
    end else if (psel && penable && pwrite && paddr == RegSrcFmt) begin
      fmt_q <= src_fmt_e'(pwdata[0]);
    end
  end

  lf2d_unpack u_unpack (.raw_i(raw_q), .fmt_i(fmt_q), .op_o(op));
  lf2d_normalise u_norm (.op_i(op), .dbl_o(dbl));

  // Pipeline advances whenever the skid stage is empty
  logic adv;
  assign adv           = !skid_vld_q;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (adv) in_vld_q <= s_axis_tvalid;
      if (out_vld_q && !m_axis_tready) begin
        // hold output; park the incoming result
        if (adv && in_vld_q) skid_vld_q <= 1'b1;
      end else begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= in_vld_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) raw_q <= s_axis_tdata;
    if (out_vld_q && !m_axis_tready) begin
      if (adv && in_vld_q) skid_q <= dbl;
    end else begin
      out_q <= skid_vld_q ? skid_q : dbl;
    end
  end
endmodule

>>> hw/rtl/lf2d_unpack.sv
// Unpack a raw word into sign, fraction and scale for either source format.
`timescale 1ns / 1ps
module lf2d_unpack (
  input  logic [lf2d_pkg::RawW-1:0] raw_i,
  input  lf2d_pkg::src_fmt_e        fmt_i,
  output lf2d_pkg::operand_t        op_o
);
  import lf2d_pkg::*;
  logic [35:0] w36;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      w36[6*k +: 6] = raw_i[8*k +: 6];
    end
    if (fmt_i == FMT_B2_36) begin
      op_o.sign  = w36[35];
      op_o.frac  = w36[26:0];
      // E - 128 - 27
      op_o.scale = $signed({3'b000, w36[34:27]}) - 11'sd155;
    end else begin
      op_o.sign  = raw_i[31];
      op_o.frac  = {3'b000, raw_i[23:0]};
      // 4*(E - 64) - 24
      op_o.scale = $signed({2'b00, raw_i[30:24], 2'b00}) - 11'sd280;
    end
  end
endmodule

>>> hw/rtl/lf2d_normalise.sv
// Normalise a fraction by leading-one search and build the double pattern.
`timescale 1ns / 1ps
module lf2d_normalise (
  input  lf2d_pkg::operand_t        op_i,
  output logic [lf2d_pkg::DblW-1:0] dbl_o
);
  import lf2d_pkg::*;
  logic [PosW-1:0]  pos;
  logic [BexpW-1:0] bexp;
  logic [51:0]      mant;
  logic [FracW-1:0] shifted;

  always_comb begin
    pos = '0;
    for (int i = 0; i < FracW; i++) begin
      if (op_i.frac[i]) pos = PosW'(i);
    end
    bexp    = BexpW'(op_i.scale) + BexpW'(pos) + BexpW'(1023);
    // place the leading one at bit FracW-1, drop it
    shifted = op_i.frac << (PosW'(FracW - 1) - pos);
    mant    = {shifted[FracW-2:0], 26'd0};
    if (op_i.frac == '0) begin
      dbl_o = {op_i.sign, 63'd0};
    end else begin
      dbl_o = {op_i.sign, bexp, mant};
    end
  end
endmodule

>>> tb/legacy_float_to_ieee_double_top_test.sv
// Testbench: mainframe float to IEEE double converter, checked against a built-in predictor.
`timescale 1ns / 1ps
module legacy_float_to_ieee_double_top_test;
  import lf2d_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [RawW-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DblW-1:0]   m_axis_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  src_fmt_e          fmt_model = FMT_B2_36;
  logic [DblW-1:0]   doubles_due[$];
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                mismatches = 0;
  int                results_seen = 0;
  int                words_sent = 0;
  int                quiet_cycles = 0;

  localparam int QuietLimit = 5000;

  legacy_float_to_ieee_double_top i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Normalise a nonzero fraction: value = frac * 2^scale
  function automatic logic [63:0] to_double(logic sgn, logic [26:0] frac, int scale);
    int msb;
    logic [63:0] wide;
    msb = 0;
    for (int i = 0; i < 27; i++) if (frac[i]) msb = i;
    wide = 64'(frac) << (52 - msb);
    return {sgn, 11'(msb + scale + 1023), wide[51:0]};
  endfunction

  function automatic logic [63:0] convert_word(logic [47:0] raw);
    logic [35:0] w36;
    if (fmt_model == FMT_B2_36) begin
      for (int k = 0; k < 6; k++) w36[6*k +: 6] = raw[8*k +: 6];
      if (w36[26:0] == '0) return {w36[35], 63'd0};
      return to_double(w36[35], w36[26:0], int'(w36[34:27]) - 128 - 27);
    end
    if (raw[23:0] == '0) return {raw[31], 63'd0};
    return to_double(raw[31], {3'd0, raw[23:0]}, 4 * (int'(raw[30:24]) - 64) - 24);
  endfunction

  // Receiver: random stall, compare every transfer with the oldest expectation
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (doubles_due.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = doubles_due.pop_front();
        if (want !== m_axis_tdata) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("ieee_double mismatch: expected %h actual %h", want, m_axis_tdata);
        end
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("legacy_float_to_ieee_double_top_test NOT OK");
      $finish;
    end
  end

  // Leaves tvalid high after the transfer; an idle gap in the next send or a drain drops it
  task automatic send_word(logic [47:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    doubles_due.push_back(convert_word(raw));
    words_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (doubles_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_format(src_fmt_e fmt);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= RegSrcFmt; pwdata <= 32'(fmt);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    fmt_model = fmt;
    @(posedge clk_i);
  endtask

  // Build a 36-bit value spread over six characters with random spare bits
  function automatic logic [47:0] pack36(logic [35:0] w);
    logic [47:0] raw;
    raw = 48'($urandom()) << 16 | 48'($urandom());
    for (int k = 0; k < 6; k++) raw[8*k +: 6] = w[6*k +: 6];
    return raw;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  task automatic test_directed_b2();
    write_format(FMT_B2_36);
    send_word(pack36({1'b0, 8'd0, 27'd0}));
    send_word(pack36({1'b1, 8'hFF, 27'd0}));
    send_word(pack36({1'b0, 8'd0, 27'd1}));
    send_word(pack36({1'b1, 8'd0, 27'h7FFFFFF}));
    send_word(pack36({1'b0, 8'hFF, 27'h7FFFFFF}));
    send_word(pack36({1'b1, 8'd128, 27'h4000000}));
    send_word(pack36({1'b0, 8'd127, 27'd3}));
    send_word(48'hFFFF_FFFF_FFFF);
    send_word(48'hC0C0_C0C0_C0C0);
    send_word(48'h0);
  endtask

  task automatic test_directed_b16();
    write_format(FMT_B16_32);
    send_word(48'h0000_0000_0000);
    send_word(48'hFFFF_8000_0000);
    send_word(48'h0000_0000_0001);
    send_word(48'h0000_FFFF_FFFF);
    send_word(48'h0000_7FFF_FFFF);
    send_word(48'h0000_4110_0000);
    send_word(48'hABCD_C0FF_FFFF);
    send_word(48'h0000_3F00_0001);
    send_word(48'h0000_0000_0000);
  endtask

  task automatic test_random(src_fmt_e fmt, int idle, int stall, int count);
    write_format(fmt);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      // zero fractions now and then to keep the signed-zero path busy
      if ($urandom_range(15) == 0)
        send_word(fmt == FMT_B2_36 ? pack36({1'($urandom_range(1)), 8'($urandom()), 27'd0})
                                   : {rand48() & 48'hFFFF_FF00_0000});
      else send_word(rand48());
    end
  endtask

  task automatic test_pause_until_empty();
    send_word(rand48());
    send_word(rand48());
    drain();
    send_word(rand48());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_b16();
    test_directed_b2();
    test_random(FMT_B2_36, 0, 0, 120);
    test_random(FMT_B16_32, 0, 0, 120);
    test_random(FMT_B2_36, 79, 0, 110);
    test_random(FMT_B16_32, 0, 79, 110);
    test_pause_until_empty();
    test_random(FMT_B2_36, 0, 79, 110);
    test_random(FMT_B16_32, 79, 0, 110);
    test_random(FMT_B2_36, 38, 38, 120);
    test_random(FMT_B16_32, 38, 38, 120);
    drain();
    $display("Converted %0d words in both source formats, %0d results checked, %0d mismatches.",
             words_sent, results_seen, mismatches);
    if (mismatches == 0 && doubles_due.size() == 0)
      $display("legacy_float_to_ieee_double_top_test OK");
    else
      $display("legacy_float_to_ieee_double_top_test NOT OK");
    $finish;
  end
endmodule
